FILE: design/pdwt_pkg.sv
// Shared types and defaults for the periodic 2-D wavelet block.
// Used by pdwt_front, pdwt_back and periodic_dwt_2d_multilevel; no dependencies.
package pdwt_pkg;

    localparam int MAX_DIMENSION_DEF = 64;
    localparam int MAX_TAPS_DEF      = 8;

    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 12;
    localparam int SAMPLE_W = 16;
    localparam int RESULT_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT    = 3'd0,
        CFG_COLUMN_COUNT = 3'd1,
        CFG_LEVEL_COUNT  = 3'd2,
        CFG_TAP_COUNT    = 3'd3,
        CFG_TAPS_LO      = 3'd4,
        CFG_TAPS_HI      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_op                        op;
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       in_range;
    } t_item;

    typedef struct packed {
        logic [6:0]  row_count;
        logic [6:0]  column_count;
        logic [2:0]  level_count;
        logic [3:0]  tap_count;
        logic [63:0] taps_lo;
        logic [63:0] taps_hi;
    } t_cfg;

endpackage

FILE: design/periodic_dwt_2d_multilevel.sv
// Top level of the periodic 2-D wavelet block: configuration registers,
// front queue and execution side. Depends on pdwt_pkg, pdwt_front, pdwt_back.
//
//   channel   direction  handshake               payload
//   input     in         push / full             i_cmd, i_element_index, i_sample_value
//   result    out        empty / pop             o_result_value, o_was_read
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Loads and reads: one per cycle while the result side pops; each result passes the
// store read register into the result queue. Run: each line is copied into the line
// buffer, then filtered over the taps in use by separate low and high multiply-accumulates.
// Reset is synchronous; stores hold no reset. A stalled result side fills the
// result queue, then the input queue, then raises full.
module periodic_dwt_2d_multilevel #(
    parameter int MAX_DIMENSION = pdwt_pkg::MAX_DIMENSION_DEF,
    parameter int MAX_TAPS      = pdwt_pkg::MAX_TAPS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [pdwt_pkg::CMD_W-1:0]             i_cmd,
    input  logic [pdwt_pkg::INDEX_W-1:0]           i_element_index,
    input  logic signed [pdwt_pkg::SAMPLE_W-1:0]   i_sample_value,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [pdwt_pkg::RESULT_W-1:0]   o_result_value,
    output logic                                   o_was_read,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pdwt_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pdwt_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    pdwt_pkg::t_cfg  r_cfg;
    pdwt_pkg::t_item w_item;
    logic            w_valid;
    logic            w_take;
    logic            w_cfg_fire;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count    <= 7'd1;
            r_cfg.column_count <= 7'd64;
            r_cfg.level_count  <= 3'd1;
            r_cfg.tap_count    <= 4'd2;
            r_cfg.taps_lo      <= 64'd759246145;
            r_cfg.taps_hi      <= 64'd0;
        end else if (w_cfg_fire) begin
            case (pdwt_pkg::t_cfg_idx'(i_cfg_index))
                pdwt_pkg::CFG_ROW_COUNT:    r_cfg.row_count    <= i_cfg_data[6:0];
                pdwt_pkg::CFG_COLUMN_COUNT: r_cfg.column_count <= i_cfg_data[6:0];
                pdwt_pkg::CFG_LEVEL_COUNT:  r_cfg.level_count  <= i_cfg_data[2:0];
                pdwt_pkg::CFG_TAP_COUNT:    r_cfg.tap_count    <= i_cfg_data[3:0];
                pdwt_pkg::CFG_TAPS_LO:      r_cfg.taps_lo      <= i_cfg_data;
                pdwt_pkg::CFG_TAPS_HI:      r_cfg.taps_hi      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pdwt_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_element_index(i_element_index),
        .i_sample_value (i_sample_value),
        .o_valid        (w_valid),
        .o_item         (w_item),
        .i_take         (w_take)
    );

    pdwt_back #(
        .MAX_DIMENSION(MAX_DIMENSION),
        .MAX_TAPS     (MAX_TAPS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_valid),
        .i_q_item      (w_item),
        .o_q_take      (w_take),
        .pop           (pop),
        .empty         (empty),
        .o_result_value(o_result_value),
        .o_was_read    (o_was_read)
    );

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_was_read) |-> (o_result_value == 32'sd0))
        else $error("non-read result carries a nonzero value");

    a_cfg_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_fire && i_cfg_index == pdwt_pkg::CFG_ROW_COUNT)
        |=> (r_cfg.row_count == $past(i_cfg_data[6:0])))
        else $error("row count write not taken");

    a_cfg_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_fire && i_cfg_index == pdwt_pkg::CFG_TAPS_LO)
        |=> (r_cfg.taps_lo == $past(i_cfg_data)))
        else $error("tap write not taken");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_valid)
        else $error("item taken from an empty queue");
endmodule

FILE: design/pdwt_front.sv
// Input side: takes commands, decodes them and holds them in a two-entry queue.
// Depends on pdwt_pkg.
module pdwt_front #(
    parameter int MAX_DIMENSION = pdwt_pkg::MAX_DIMENSION_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [pdwt_pkg::CMD_W-1:0]           i_cmd,
    input  logic [pdwt_pkg::INDEX_W-1:0]         i_element_index,
    input  logic signed [pdwt_pkg::SAMPLE_W-1:0] i_sample_value,
    output logic                                 o_valid,
    output pdwt_pkg::t_item                      o_item,
    input  logic                                 i_take
);
    localparam int DEPTH = MAX_DIMENSION * MAX_DIMENSION;

    pdwt_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    pdwt_pkg::t_item n_item;
    logic            w_in;
    logic            w_out;

    always_comb begin
        case (i_cmd)
            2'd0:    n_item.op = pdwt_pkg::OP_LOAD;
            2'd1:    n_item.op = pdwt_pkg::OP_RUN;
            2'd2:    n_item.op = pdwt_pkg::OP_READ;
            default: n_item.op = pdwt_pkg::OP_NONE;
        endcase
        n_item.index    = i_element_index;
        n_item.sample   = i_sample_value;
        n_item.in_range = (32'(i_element_index) < DEPTH);
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_in    = push && !full;
    assign w_out   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) begin
                r_wp <= !r_wp;
            end
            if (w_out) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
    end
endmodule

FILE: design/pdwt_back.sv
// Execution side: matrix store, line buffer, filter sequencer and result queue.
// Depends on pdwt_pkg; fed by pdwt_front.
module pdwt_back #(
    parameter int MAX_DIMENSION = pdwt_pkg::MAX_DIMENSION_DEF,
    parameter int MAX_TAPS      = pdwt_pkg::MAX_TAPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pdwt_pkg::t_cfg                       i_cfg,
    input  logic                                 i_q_valid,
    input  pdwt_pkg::t_item                      i_q_item,
    output logic                                 o_q_take,
    input  logic                                 pop,
    output logic                                 empty,
    output logic signed [pdwt_pkg::RESULT_W-1:0] o_result_value,
    output logic                                 o_was_read
);
    localparam int DEPTH = MAX_DIMENSION * MAX_DIMENSION;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAX_DIMENSION);
    localparam int CW    = $clog2(2 * MAX_DIMENSION + 1);
    localparam int TW    = $clog2(MAX_TAPS + 1);
    localparam int PW    = 49;
    localparam int ACCW  = PW + $clog2(MAX_TAPS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LEVEL, S_LINE, S_LOAD, S_LDRAIN, S_FILT, S_FWAIT, S_WRLO, S_WRHI, S_DONE
    } t_state;

    function automatic logic signed [15:0] tap_value(input logic [4:0] k,
                                                     input logic [63:0] lo,
                                                     input logic [63:0] hi);
        logic [63:0] w;
        w = (k < 5'd4) ? lo : hi;
        if (k >= 5'd8) begin
            return 16'sd0;
        end
        return w[16 * k[1:0] +: 16];
    endfunction

    function automatic logic signed [31:0] sat_round(input logic signed [ACCW-1:0] a);
        logic signed [ACCW-1:0] q;
        q = (a + ACCW'(8192)) >>> 14;
        if (q > ACCW'(64'sd2147483647)) begin
            return 32'sh7fffffff;
        end
        if (q < ACCW'(-64'sd2147483648)) begin
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_line_mem [MAX_DIMENSION];

    t_state                 r_state;
    logic [CW-1:0]          r_m, r_cur_rows, r_cur_cols, r_half_rows, r_half_cols;
    logic [2:0]             r_lvl;
    logic                   r_col_pass;
    logic [CW-1:0]          r_l, r_len, r_half, r_i, r_k, r_pstart, r_p;
    logic [AW-1:0]          r_base, r_stride, r_addr, r_wlo, r_whi;
    logic [TW-1:0]          r_j, r_taps_used;
    logic                   r_ld_v;
    logic [LW-1:0]          r_ld_i;
    logic                   r_fa_v, r_fa_last;
    logic signed [15:0]     r_fa_lo;
    logic signed [16:0]     r_fa_hi;
    logic signed [31:0]     r_line_q;
    logic                   r_pb_v, r_pb_last;
    logic signed [PW-1:0]   r_pl, r_ph;
    logic signed [ACCW-1:0] r_acc_lo, r_acc_hi;
    logic                   r_s1_valid, r_s1_read, r_s1_inr;
    logic signed [31:0]     r_rdata;
    logic signed [31:0]     r_of_value [2];
    logic                   r_of_read [2];
    logic                   r_of_wp, r_of_rp;
    logic [1:0]             r_of_cnt;

    logic                   w_pop;
    logic [2:0]             w_load;
    logic                   w_take;
    logic                   w_we;
    logic [AW-1:0]          w_wa, w_ra;
    logic signed [31:0]     w_wd;
    logic [CW-1:0]          w_m, w_n;
    logic [TW-1:0]          w_rev;
    logic signed [15:0]     w_tlo, w_trev;
    logic [CW-1:0]          w_p_inc;

    assign w_pop  = pop && !empty;
    assign w_load = 3'(r_of_cnt) + 3'(r_s1_valid) - 3'(w_pop);
    assign w_take = i_q_valid && (r_state == S_IDLE) && (w_load <= 3'd1);
    assign o_q_take = w_take;

    always_comb begin
        if (i_cfg.row_count == 7'd0) begin
            w_m = CW'(1);
        end else if (int'(i_cfg.row_count) > MAX_DIMENSION) begin
            w_m = CW'(MAX_DIMENSION);
        end else begin
            w_m = CW'(i_cfg.row_count);
        end
        if (i_cfg.column_count == 7'd0) begin
            w_n = CW'(1);
        end else if (int'(i_cfg.column_count) > MAX_DIMENSION) begin
            w_n = CW'(MAX_DIMENSION);
        end else begin
            w_n = CW'(i_cfg.column_count);
        end
    end

    assign w_rev   = r_taps_used - TW'(1) - r_j;
    assign w_tlo   = tap_value(5'(r_j), i_cfg.taps_lo, i_cfg.taps_hi);
    assign w_trev  = tap_value(5'(w_rev), i_cfg.taps_lo, i_cfg.taps_hi);
    assign w_p_inc = (r_p + CW'(1) == r_len) ? CW'(0) : r_p + CW'(1);

    always_comb begin
        w_ra = (r_state == S_IDLE) ? AW'(i_q_item.index) : r_addr;
        w_we = 1'b0;
        w_wa = AW'(i_q_item.index);
        w_wd = 32'(i_q_item.sample);
        case (r_state)
            S_IDLE: begin
                w_we = w_take && (i_q_item.op == pdwt_pkg::OP_LOAD) && i_q_item.in_range;
            end
            S_WRLO: begin
                w_we = 1'b1;
                w_wa = r_wlo;
                w_wd = sat_round(r_acc_lo);
            end
            S_WRHI: begin
                w_we = 1'b1;
                w_wa = r_whi;
                w_wd = sat_round(r_acc_hi);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[w_ra];
        if (r_ld_v) begin
            r_line_mem[r_ld_i] <= r_rdata;
        end
        r_line_q <= r_line_mem[r_p[LW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_pl      <= r_line_q * r_fa_lo;
        r_ph      <= r_line_q * r_fa_hi;
        r_pb_last <= r_fa_last;
        r_ld_i    <= r_i[LW-1:0];
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ld_v     <= 1'b0;
            r_fa_v     <= 1'b0;
            r_pb_v     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_ld_v     <= 1'b0;
            r_fa_v     <= 1'b0;
            r_pb_v     <= r_fa_v;
            r_s1_valid <= 1'b0;
            if (r_pb_v) begin
                r_acc_lo <= r_acc_lo + ACCW'(r_pl);
                r_acc_hi <= r_acc_hi + ACCW'(r_ph);
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        if (i_q_item.op == pdwt_pkg::OP_RUN) begin
                            r_m         <= w_m;
                            r_cur_rows  <= w_m << 1;
                            r_cur_cols  <= w_n << 1;
                            r_half_rows <= '0;
                            r_lvl       <= 3'd0;
                            r_taps_used <= (int'(i_cfg.tap_count) > MAX_TAPS) ?
                                           TW'(MAX_TAPS) : TW'(i_cfg.tap_count);
                            r_state     <= S_LEVEL;
                        end else begin
                            r_s1_valid <= 1'b1;
                            r_s1_read  <= (i_q_item.op == pdwt_pkg::OP_READ);
                            r_s1_inr   <= i_q_item.in_range;
                        end
                    end
                end
                S_LEVEL: begin
                    if (r_lvl == i_cfg.level_count) begin
                        r_state <= S_DONE;
                    end else begin
                        if (r_m == CW'(1)) begin
                            r_cur_rows <= CW'(1);
                        end else begin
                            r_cur_rows  <= r_cur_rows >> 1;
                            r_half_rows <= r_cur_rows >> 2;
                        end
                        r_cur_cols  <= r_cur_cols >> 1;
                        r_half_cols <= r_cur_cols >> 2;
                        r_lvl       <= r_lvl + 3'd1;
                        r_col_pass  <= 1'b0;
                        r_l         <= '0;
                        r_base      <= '0;
                        r_state     <= S_LINE;
                    end
                end
                S_LINE: begin
                    r_addr <= r_base;
                    r_wlo  <= r_base;
                    r_i    <= '0;
                    if (!r_col_pass) begin
                        if (r_half_cols == '0 || r_l == r_cur_rows) begin
                            r_col_pass <= 1'b1;
                            r_l        <= '0;
                            r_base     <= '0;
                        end else begin
                            r_stride <= AW'(r_m);
                            r_len    <= r_cur_cols;
                            r_half   <= r_half_cols;
                            r_state  <= S_LOAD;
                        end
                    end else begin
                        if (r_m == CW'(1) || r_half_rows == '0 || r_l == r_cur_cols) begin
                            r_state <= S_LEVEL;
                        end else begin
                            r_stride <= AW'(1);
                            r_len    <= r_cur_rows;
                            r_half   <= r_half_rows;
                            r_state  <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_ld_v <= 1'b1;
                    r_addr <= r_addr + r_stride;
                    if (r_i == r_half) begin
                        r_whi <= r_addr;
                    end
                    r_i <= r_i + CW'(1);
                    if (r_i == r_len - CW'(1)) begin
                        r_state <= S_LDRAIN;
                    end
                end
                S_LDRAIN: begin
                    r_k      <= '0;
                    r_pstart <= '0;
                    r_p      <= '0;
                    r_j      <= '0;
                    r_acc_lo <= '0;
                    r_acc_hi <= '0;
                    r_state  <= S_FILT;
                end
                S_FILT: begin
                    if (r_taps_used == '0) begin
                        r_state <= S_WRLO;
                    end else begin
                        r_fa_v    <= 1'b1;
                        r_fa_lo   <= w_tlo;
                        r_fa_hi   <= w_rev[0] ? 17'(w_trev) : -17'(w_trev);
                        r_fa_last <= (r_j == r_taps_used - TW'(1));
                        r_p       <= w_p_inc;
                        r_j       <= r_j + TW'(1);
                        if (r_j == r_taps_used - TW'(1)) begin
                            r_state <= S_FWAIT;
                        end
                    end
                end
                S_FWAIT: begin
                    if (r_pb_v && r_pb_last) begin
                        r_state <= S_WRLO;
                    end
                end
                S_WRLO: begin
                    r_state <= S_WRHI;
                end
                S_WRHI: begin
                    r_wlo <= r_wlo + r_stride;
                    r_whi <= r_whi + r_stride;
                    if (r_k == r_half - CW'(1)) begin
                        r_l     <= r_l + CW'(1);
                        r_base  <= r_base + (r_col_pass ? AW'(r_m) : AW'(1));
                        r_state <= S_LINE;
                    end else begin
                        r_k      <= r_k + CW'(1);
                        r_pstart <= r_pstart + CW'(2);
                        r_p      <= r_pstart + CW'(2);
                        r_j      <= '0;
                        r_acc_lo <= '0;
                        r_acc_hi <= '0;
                        r_state  <= S_FILT;
                    end
                end
                S_DONE: begin
                    r_s1_valid <= 1'b1;
                    r_s1_read  <= 1'b0;
                    r_s1_inr   <= 1'b0;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign empty          = (r_of_cnt == 2'd0);
    assign o_result_value = r_of_value[r_of_rp];
    assign o_was_read     = r_of_read[r_of_rp];

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_of_value[r_of_wp] <= (r_s1_read && r_s1_inr) ? r_rdata : 32'sd0;
            r_of_read[r_of_wp]  <= r_s1_read;
        end
        if (!i_rst_n) begin
            r_of_wp  <= 1'b0;
            r_of_rp  <= 1'b0;
            r_of_cnt <= 2'd0;
        end else begin
            if (r_s1_valid) begin
                r_of_wp <= !r_of_wp;
            end
            if (w_pop) begin
                r_of_rp <= !r_of_rp;
            end
            r_of_cnt <= r_of_cnt + 2'(r_s1_valid) - 2'(w_pop);
        end
    end
endmodule
